@@ rtl/apcs_pkg.sv @@
// Shared types and constants of the rectangle pair collision scan.
package apcs_pkg;

    localparam int TYPE_W     = 3;
    localparam int SLOT_F_W   = 3;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 15;
    localparam int MASK_W     = 64;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_SCAN    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]               kind;
        logic [SLOT_F_W-1:0]      slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [SIZE_W-1:0]        size_w;
        logic [SIZE_W-1:0]        size_h;
        logic [TYPE_W-1:0]        obj_type;
        logic                     enable;
        logic                     wants_notice;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_F_W-1:0] first_slot;
        logic [SLOT_F_W-1:0] second_slot;
        logic                first_notified;
        logic                second_notified;
        logic                table_full;
        logic                is_report;
        logic                last;
    } t_out_beat;

    typedef struct packed {
        logic hit;
        logic first_notified;
        logic second_notified;
    } t_verdict;

endpackage

@@ rtl/apcs_pair_test.sv @@
// Overlap and notification decision for one pair of stored rectangles.
module apcs_pair_test
    import apcs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TYPE_COUNT = 8
) (
    input  logic signed [COORD_BITS-1:0] i_left_a,
    input  logic signed [COORD_BITS-1:0] i_top_a,
    input  logic [SIZE_W-1:0]            i_width_a,
    input  logic [SIZE_W-1:0]            i_height_a,
    input  logic [TYPE_W-1:0]            i_type_a,
    input  logic                         i_notify_a,
    input  logic signed [COORD_BITS-1:0] i_left_b,
    input  logic signed [COORD_BITS-1:0] i_top_b,
    input  logic [SIZE_W-1:0]            i_width_b,
    input  logic [SIZE_W-1:0]            i_height_b,
    input  logic [TYPE_W-1:0]            i_type_b,
    input  logic                         i_notify_b,
    input  logic [MASK_W-1:0]            i_pair_mask,
    output t_verdict                     o_verdict
);

    // Wide enough that an edge plus a size can never wrap.
    localparam int SUM_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

    logic signed [SUM_W-1:0] la, ta, wa, ha, lb, tb, wb, hb;
    logic                    type_a_ok, type_b_ok, allow_ab, allow_ba;

    always_comb begin
        la = SUM_W'(i_left_a);
        ta = SUM_W'(i_top_a);
        wa = SUM_W'(i_width_a);
        ha = SUM_W'(i_height_a);
        lb = SUM_W'(i_left_b);
        tb = SUM_W'(i_top_b);
        wb = SUM_W'(i_width_b);
        hb = SUM_W'(i_height_b);

        // Touching edges still count as a hit.
        o_verdict.hit = !((la + wa) < lb) && !((lb + wb) < la) &&
                        !((ta + ha) < tb) && !((tb + hb) < ta);

        type_a_ok = (int'(i_type_a) < TYPE_COUNT);
        type_b_ok = (int'(i_type_b) < TYPE_COUNT);
        allow_ab  = type_a_ok && type_b_ok && i_pair_mask[{i_type_a, i_type_b}];
        allow_ba  = type_a_ok && type_b_ok && i_pair_mask[{i_type_b, i_type_a}];

        o_verdict.first_notified  = allow_ab && i_notify_a;
        o_verdict.second_notified = allow_ba && i_notify_b;
    end

endmodule

@@ rtl/aabb_pair_collision_scan.sv @@
// Top level of the rectangle collision table with its pairwise overlap scan.
//
// The block holds SLOTS axis-aligned rectangles, each with a collider type, an
// active flag and a notify flag. Add, update and release beats each give one
// acknowledgement beat; an add stores into the lowest free slot and reports it,
// or flags table_full. A scan beat walks every pair i<k of slots, one pair per
// clock through a single shared overlap unit, and emits one report beat for each
// overlapping pair of valid, active entries where pair_mask lets at least one
// side with its notify flag set be told, followed by an end marker with last set.
// Flow: an add, update or release is accepted into a pending result, which moves
// into the output register once that register is free. A scan sends each pair
// from the pair sequencer, which reads both entries from rectangle memory, through
// a registered read stage into the compare stage; after the last pair has been
// compared, the end marker goes through the pending result into the output
// register. Any cycle in which a report waits on a full output register holds
// the whole scan for that cycle. The block takes no new input beat until the
// current one has handed its last result to the output register, but it does
// accept while that result still waits downstream. The pair_mask register sits
// at byte address 0 of the APB-style port and must only be written while the
// block is idle. Rectangles use COORD_BITS-wide edges; input positions are
// sign-extended or wrapped to that width on entry.
module aabb_pair_collision_scan
    import apcs_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int TYPE_COUNT = 8,
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LAST_I = SLOTS - 2;
    localparam int LAST_K = SLOTS - 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [SIZE_W-1:0]            width;
        logic [SIZE_W-1:0]            height;
    } t_rect;

    // Rectangle and type storage: written at one address, read at two.
    t_rect             r_rect_mem [SLOTS];
    logic [TYPE_W-1:0] r_type_mem [SLOTS];

    logic [SLOTS-1:0]  r_valid, r_active, r_notify;
    logic [MASK_W-1:0] r_pair_mask;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_pi, n_pi, r_pk, n_pk;
    logic              r_a_more, n_a_more;
    logic              r_b_valid, n_b_valid;
    logic [SLOT_W-1:0] r_b_i, n_b_i, r_b_k, n_b_k;
    t_rect             r_rd_a, r_rd_b;
    logic [TYPE_W-1:0] r_rdt_a, r_rdt_b;
    t_out_beat         r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic              in_acc, cfg_wr, rd_en;
    logic              free_found, slot_ok, upd_ok;
    logic [SLOT_W-1:0] free_idx, slot_idx;
    t_rect             new_rect;
    t_verdict          verdict;
    logic              b_live, b_report, out_free, stall, advance;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Configuration port: a single 64-bit register, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[3];
    assign prdata = paddr[3] ? '0 : r_pair_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_mask <= '0;
        end else if (cfg_wr) begin
            r_pair_mask <= pwdata;
        end
    end

    // Decode of the incoming beat: lowest free slot, slot range and new rectangle.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
        slot_ok  = (int'(i_in_beat.slot) < SLOTS);
        slot_idx = SLOT_W'(i_in_beat.slot);
        upd_ok   = slot_ok && r_valid[slot_idx];

        new_rect.left   = COORD_BITS'(i_in_beat.pos_x);
        new_rect.top    = COORD_BITS'(i_in_beat.pos_y);
        new_rect.width  = i_in_beat.size_w;
        new_rect.height = i_in_beat.size_h;
    end

    // Entry flags live in flip-flops so that reset clears the table at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
            r_notify <= '0;
        end else if (in_acc) begin
            case (i_in_beat.kind)
                OP_ADD: begin
                    if (free_found) begin
                        r_valid[free_idx]  <= 1'b1;
                        r_active[free_idx] <= i_in_beat.enable;
                        r_notify[free_idx] <= i_in_beat.wants_notice;
                    end
                end
                OP_UPDATE: begin
                    if (upd_ok) begin
                        r_active[slot_idx] <= i_in_beat.enable;
                    end
                end
                OP_RELEASE: begin
                    if (slot_ok) begin
                        r_valid[slot_idx]  <= 1'b0;
                        r_active[slot_idx] <= 1'b0;
                        r_notify[slot_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Storage writes and the registered two-port read for the pair sequencer.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_beat.kind == OP_ADD) && free_found) begin
            r_rect_mem[free_idx] <= new_rect;
            r_type_mem[free_idx] <= i_in_beat.obj_type;
        end else if (in_acc && (i_in_beat.kind == OP_UPDATE) && upd_ok) begin
            r_rect_mem[slot_idx] <= new_rect;
        end
        if (rd_en) begin
            r_rd_a  <= r_rect_mem[r_pi];
            r_rd_b  <= r_rect_mem[r_pk];
            r_rdt_a <= r_type_mem[r_pi];
            r_rdt_b <= r_type_mem[r_pk];
        end
    end

    // The one overlap unit, shared by every pair of the scan.
    apcs_pair_test #(
        .COORD_BITS (COORD_BITS),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_pair_test (
        .i_left_a    (r_rd_a.left),
        .i_top_a     (r_rd_a.top),
        .i_width_a   (r_rd_a.width),
        .i_height_a  (r_rd_a.height),
        .i_type_a    (r_rdt_a),
        .i_notify_a  (r_notify[r_b_i]),
        .i_left_b    (r_rd_b.left),
        .i_top_b     (r_rd_b.top),
        .i_width_b   (r_rd_b.width),
        .i_height_b  (r_rd_b.height),
        .i_type_b    (r_rdt_b),
        .i_notify_b  (r_notify[r_b_k]),
        .i_pair_mask (r_pair_mask),
        .o_verdict   (verdict)
    );

    // A pair only reports when both entries are live, they touch, and at
    // least one side is to be told.
    always_comb begin
        b_live   = r_valid[r_b_i] && r_active[r_b_i] && r_valid[r_b_k] && r_active[r_b_k];
        b_report = r_b_valid && b_live && verdict.hit &&
                   (verdict.first_notified || verdict.second_notified);
        out_free = !r_out_valid || i_out_ready;
        stall    = b_report && !out_free;
        advance  = !stall;
        rd_en    = (r_state == S_SCAN) && advance && r_a_more;
    end

    // Sequencer: one pair per cycle unless stalled; fills the output register.
    always_comb begin
        n_state     = r_state;
        n_pi        = r_pi;
        n_pk        = r_pk;
        n_a_more    = r_a_more;
        n_b_valid   = r_b_valid;
        n_b_i       = r_b_i;
        n_b_k       = r_b_k;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pend      = '0;
                    n_pend.last = 1'b1;
                    case (i_in_beat.kind)
                        OP_ADD: begin
                            if (free_found) begin
                                n_pend.first_slot = SLOT_F_W'(free_idx);
                            end else begin
                                n_pend.table_full = 1'b1;
                            end
                            n_state = S_PUT;
                        end
                        OP_UPDATE, OP_RELEASE: begin
                            n_state = S_PUT;
                        end
                        OP_SCAN: begin
                            n_pi      = '0;
                            n_pk      = SLOT_W'(1);
                            n_a_more  = 1'b1;
                            n_b_valid = 1'b0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (advance) begin
                    if (b_report) begin
                        n_out_valid           = 1'b1;
                        n_out                 = '0;
                        n_out.first_slot      = SLOT_F_W'(r_b_i);
                        n_out.second_slot     = SLOT_F_W'(r_b_k);
                        n_out.first_notified  = verdict.first_notified;
                        n_out.second_notified = verdict.second_notified;
                        n_out.is_report       = 1'b1;
                    end
                    if (r_a_more) begin
                        n_b_valid = 1'b1;
                        n_b_i     = r_pi;
                        n_b_k     = r_pk;
                        if (r_pk == SLOT_W'(LAST_K)) begin
                            if (r_pi == SLOT_W'(LAST_I)) begin
                                n_a_more = 1'b0;
                            end else begin
                                n_pi = r_pi + SLOT_W'(1);
                                n_pk = r_pi + SLOT_W'(2);
                            end
                        end else begin
                            n_pk = r_pk + SLOT_W'(1);
                        end
                    end else begin
                        // Last pair has left the compare stage: close the scan.
                        n_b_valid   = 1'b0;
                        n_pend      = '0;
                        n_pend.last = 1'b1;
                        n_state     = S_PUT;
                    end
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_more    <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a_more    <= n_a_more;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi   <= n_pi;
        r_pk   <= n_pk;
        r_b_i  <= n_b_i;
        r_b_k  <= n_b_k;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // When new beats are taken, no scan work may still be in flight.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_b_valid && !r_a_more))
        else $error("input ready while scan still in flight");

    // A pair report is never the closing beat and never a table-full result.
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_report) |-> (!r_out.last && !r_out.table_full))
        else $error("malformed pair report");

    // A successful add occupies exactly one more slot.
    a_add_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_beat.kind == OP_ADD) && free_found) |=>
        ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("add did not take exactly one slot");

    // A blocked report keeps its pair in the compare stage.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && stall) |=>
        (r_b_valid && $stable(r_b_i) && $stable(r_b_k)))
        else $error("blocked pair lost from compare stage");
`endif

endmodule
